/* rtl/core/led_blink_pattern_queue_macros.svh */
// Assertion macros shared by the LED pattern queue RTL.
// Every property is clocked on clk and disabled while arst_n is low.
`ifndef LED_BLINK_PATTERN_QUEUE_MACROS_SVH
`define LED_BLINK_PATTERN_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LBPQ_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lbpq assertion failed");
`define LBPQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lbpq assertion failed");
`else
`define LBPQ_ASSERT_SAME(label, ante, cons)
`define LBPQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/core/lbpq_pkg.sv */
package lbpq_pkg;

	localparam int FIFO_DEPTH_DEF   = 32;
	localparam int RAPID_PULSES_DEF = 3;

	localparam int TICK_W     = 20;
	localparam int FILL_OUT_W = 6;
	localparam int CFG_IDX_W  = 2;

	localparam logic              LED_ENABLE_RST  = 1'b1;
	localparam logic [TICK_W-1:0] SHORT_TICKS_RST = 20'd100;
	localparam logic [TICK_W-1:0] LONG_TICKS_RST  = 20'd500;
	localparam logic [TICK_W-1:0] GAP_TICKS_RST   = 20'd100;

	typedef enum logic [1:0] {
		PAT_NONE  = 2'd0,
		PAT_SHORT = 2'd1,
		PAT_LONG  = 2'd2,
		PAT_RAPID = 2'd3
	} pat_t;

	typedef enum logic [0:0] {
		ACT_TICK    = 1'b0,
		ACT_ENQUEUE = 1'b1
	} act_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LED_ENABLE  = 2'd0,
		CFG_SHORT_TICKS = 2'd1,
		CFG_LONG_TICKS  = 2'd2,
		CFG_GAP_TICKS   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		act_t action;
		pat_t pattern;
	} req_t;

	typedef struct packed {
		logic                  led_level;
		logic [FILL_OUT_W-1:0] queue_fill;
		logic                  dropped;
		logic                  busy_res;
	} res_t;

	typedef struct packed {
		logic push;
		logic pop;
		pat_t wdata;
	} fifo_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
		pat_t head;
	} fifo_sts_t;

endpackage

/* rtl/core/lbpq_stream_if.sv */
interface lbpq_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/lbpq_fifo.sv */
`include "led_blink_pattern_queue_macros.svh"

module lbpq_fifo #(
	parameter int DEPTH = lbpq_pkg::FIFO_DEPTH_DEF,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lbpq_pkg::fifo_ctl_t ctl,
	output lbpq_pkg::fifo_sts_t sts,
	output logic [CW-1:0]      fill
);
	import lbpq_pkg::*;

	localparam int AW = $clog2(DEPTH);

	pat_t          mem [DEPTH];
	logic [AW-1:0] rp_q;
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_n;
	logic [AW-1:0] wp_n;
	logic [CW-1:0] fill_q;
	pat_t          rd_q;
	logic          fwd_q;
	pat_t          fwd_data_q;

	always_comb begin
		rp_n = rp_q;
		if (ctl.pop) begin
			rp_n = (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
		end
		wp_n = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
	end

	// The read port always fetches the entry the head will point at next cycle.
	// A write to that same entry in this cycle is forwarded around the memory.
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[wp_q] <= ctl.wdata;
		end
		rd_q       <= mem[rp_n];
		fwd_data_q <= ctl.wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q   <= '0;
			wp_q   <= '0;
			fill_q <= '0;
			fwd_q  <= 1'b0;
		end else begin
			rp_q  <= rp_n;
			fwd_q <= ctl.push && (wp_q == rp_n);
			if (ctl.push) begin
				wp_q <= wp_n;
			end
			unique case ({ctl.push, ctl.pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	assign sts.empty = (fill_q == '0);
	assign sts.full  = (fill_q == CW'(DEPTH));
	assign sts.head  = fwd_q ? fwd_data_q : rd_q;
	assign fill      = fill_q;

	`LBPQ_ASSERT_SAME(a_fill_bound, 1'b1, fill_q <= CW'(DEPTH))
	`LBPQ_ASSERT_SAME(a_no_push_full, ctl.push, !sts.full)
	`LBPQ_ASSERT_SAME(a_no_pop_empty, ctl.pop, !sts.empty)
	`LBPQ_ASSERT_NEXT(a_fill_grows, ctl.push && !ctl.pop, fill_q == $past(fill_q) + 1'b1)
endmodule

/* rtl/core/led_blink_pattern_queue.sv */
// LED blink pattern queue.
// Requests arrive on the req stream (valid/ready); action selects either a
// time tick or a pattern request (short, long, rapid). Every request yields
// exactly one result on the res stream: LED level, queue fill, a dropped
// flag for a request lost to a full queue, and a busy flag while a pattern
// plays. Enqueues are ignored while led_enable is zero or for pattern none.
// Only ticks advance playback; each phase stays up for its programmed count.
// Registers are written through cfg_we/cfg_index/cfg_data only while idle;
// the user must enforce it, not the block. A request passes one input
// stage, then the result register that also holds the player state. One
// request is taken every cycle; the only state update per request is one
// queue step plus one 20-bit timer step. If res.ready stays low, the result
// holds, the input stage fills and req.ready drops; nothing is lost or
// reordered. Reset empties the queue, idles the player, turns the LED off
// and loads the register defaults (enable 1, short 100, long 500, gap 100).
`include "led_blink_pattern_queue_macros.svh"

module led_blink_pattern_queue #(
	parameter int FIFO_DEPTH   = lbpq_pkg::FIFO_DEPTH_DEF,
	parameter int RAPID_PULSES = lbpq_pkg::RAPID_PULSES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lbpq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lbpq_pkg::TICK_W-1:0]    cfg_data,
	lbpq_stream_if.sink                    req,
	lbpq_stream_if.source                  res
);
	import lbpq_pkg::*;

	localparam int CW   = $clog2(FIFO_DEPTH + 1);
	localparam int LAST = 2 * RAPID_PULSES - 2;
	localparam int PW   = (LAST > 0) ? $clog2(LAST + 1) : 1;

	logic              led_enable_q;
	logic [TICK_W-1:0] short_q;
	logic [TICK_W-1:0] long_q;
	logic [TICK_W-1:0] gap_q;

	logic valid_s1;
	req_t item_s1;
	logic res_valid_q;
	logic adv;

	pat_t              active_q;
	logic [PW-1:0]     phase_q;
	logic [TICK_W-1:0] timer_q;
	logic              led_q;
	logic              dropped_q;

	pat_t              active_n;
	logic [PW-1:0]     phase_n;
	logic [TICK_W-1:0] timer_n;
	logic              led_n;
	logic              drop_n;

	pat_t              ld_pat;
	logic              ld_odd;
	logic [TICK_W-1:0] ld_timer;
	logic              ld_led;
	logic [PW-1:0]     last_phase;
	logic              wants_queue;

	fifo_ctl_t     fctl;
	fifo_sts_t     fsts;
	logic [CW-1:0] fill;

	lbpq_fifo #(
		.DEPTH (FIFO_DEPTH),
		.CW    (CW)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (fctl),
		.sts    (fsts),
		.fill   (fill)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_enable_q <= LED_ENABLE_RST;
			short_q      <= SHORT_TICKS_RST;
			long_q       <= LONG_TICKS_RST;
			gap_q        <= GAP_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_LED_ENABLE:  led_enable_q <= cfg_data[0];
				CFG_SHORT_TICKS: short_q      <= cfg_data;
				CFG_LONG_TICKS:  long_q       <= cfg_data;
				CFG_GAP_TICKS:   gap_q        <= cfg_data;
			endcase
		end
	end

	// The stage moves forward whenever the result slot is free or being taken.
	assign adv       = valid_s1 && (!res_valid_q || res.ready);
	assign req.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.data;
		end
	end

	assign wants_queue = (item_s1.action == ACT_ENQUEUE) && led_enable_q
		&& (item_s1.pattern != PAT_NONE);
	assign last_phase  = (active_q == PAT_RAPID) ? PW'(LAST) : '0;

	// A new phase comes either from the popped head or from the next phase
	// of the pattern in play. Even phases light the LED, odd ones are gaps.
	always_comb begin
		if (active_q == PAT_NONE) begin
			ld_pat = fsts.head;
			ld_odd = 1'b0;
		end else begin
			ld_pat = active_q;
			ld_odd = ~phase_q[0];
		end
		if (ld_pat == PAT_LONG) begin
			ld_timer = long_q;
			ld_led   = 1'b1;
		end else if (ld_odd) begin
			ld_timer = gap_q;
			ld_led   = 1'b0;
		end else begin
			ld_timer = short_q;
			ld_led   = 1'b1;
		end
	end

	always_comb begin
		active_n   = active_q;
		phase_n    = phase_q;
		timer_n    = timer_q;
		led_n      = led_q;
		drop_n     = wants_queue && fsts.full;
		fctl.push  = adv && wants_queue && !fsts.full;
		fctl.pop   = 1'b0;
		fctl.wdata = item_s1.pattern;
		if (item_s1.action == ACT_TICK) begin
			if (active_q == PAT_NONE) begin
				if (!fsts.empty) begin
					fctl.pop = adv;
					active_n = fsts.head;
					phase_n  = '0;
					if (fsts.head != PAT_NONE) begin
						timer_n = ld_timer;
						led_n   = ld_led;
					end
				end
			end else if (timer_q > TICK_W'(1)) begin
				timer_n = timer_q - 1'b1;
			end else if (phase_q >= last_phase) begin
				active_n = PAT_NONE;
				phase_n  = '0;
				timer_n  = '0;
				led_n    = 1'b0;
			end else begin
				phase_n = phase_q + 1'b1;
				timer_n = ld_timer;
				led_n   = ld_led;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			active_q    <= PAT_NONE;
			phase_q     <= '0;
			timer_q     <= '0;
			led_q       <= 1'b0;
		end else begin
			if (adv) begin
				res_valid_q <= 1'b1;
				active_q    <= active_n;
				phase_q     <= phase_n;
				timer_q     <= timer_n;
				led_q       <= led_n;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dropped_q <= drop_n;
		end
	end

	// Player state only changes when a result is loaded, so it is the result.
	assign res.valid           = res_valid_q;
	assign res.data.led_level  = led_q;
	assign res.data.queue_fill = FILL_OUT_W'(fill);
	assign res.data.dropped    = dropped_q;
	assign res.data.busy_res   = (active_q != PAT_NONE);

	`LBPQ_ASSERT_SAME(a_idle_dark, active_q == PAT_NONE, !led_q)
	`LBPQ_ASSERT_SAME(a_idle_clear, active_q == PAT_NONE, phase_q == '0 && timer_q == '0)
	`LBPQ_ASSERT_SAME(a_phase_bound, 1'b1, phase_q <= PW'(LAST))
	`LBPQ_ASSERT_SAME(a_gap_dark, phase_q[0], !led_q)
endmodule

/* dv/led_blink_pattern_queue_tb.sv */
module led_blink_pattern_queue_tb;
	import lbpq_pkg::*;

	localparam int unsigned    CYCLE_LIMIT = 400000;
	localparam logic [2:0]     LAST_RAPID_PHASE = 3'(2 * RAPID_PULSES_DEF - 2);
	localparam logic [TICK_W-1:0] TICKS_MAX = '1;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TICK_W-1:0]    cfg_data;

	lbpq_stream_if #(.payload_t(req_t)) req_if ();
	lbpq_stream_if #(.payload_t(res_t)) res_if ();

	led_blink_pattern_queue u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_if),
		.res       (res_if)
	);

	// Shadow copy of the registers and of the player.
	logic              en_q;
	logic [TICK_W-1:0] short_q;
	logic [TICK_W-1:0] long_q;
	logic [TICK_W-1:0] gap_q;
	pat_t              pat_waiting[$];
	pat_t              play_pat;
	logic [2:0]        play_phase;
	logic [TICK_W-1:0] play_timer;
	logic              led_q;

	req_t        req_backlog[$];
	res_t        expected_status[$];
	int unsigned submitted_cnt = 0;
	int unsigned accepted_cnt = 0;
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned send_gap = 0;
	int unsigned hold_cnt = 0;
	logic        calm = 1'b0;
	logic        req_fire = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Even phases light the LED, odd phases are the gaps of the rapid pattern.
	function automatic void load_phase();
		if (play_pat == PAT_LONG) begin
			play_timer = long_q;
			led_q = 1'b1;
		end else if (play_phase[0]) begin
			play_timer = gap_q;
			led_q = 1'b0;
		end else begin
			play_timer = short_q;
			led_q = 1'b1;
		end
	endfunction

	function automatic res_t step_player(req_t item);
		res_t       r;
		logic       drop;
		logic [2:0] last;
		drop = 1'b0;
		if (item.action == ACT_TICK) begin
			if (play_pat == PAT_NONE) begin
				if (pat_waiting.size() != 0) begin
					play_pat = pat_waiting.pop_front();
					play_phase = '0;
					if (play_pat != PAT_NONE)
						load_phase();
				end
			end else if (play_timer > 1) begin
				play_timer = play_timer - 1'b1;
			end else begin
				last = (play_pat == PAT_RAPID) ? LAST_RAPID_PHASE : 3'd0;
				if (play_phase >= last) begin
					play_pat = PAT_NONE;
					play_phase = '0;
					play_timer = '0;
					led_q = 1'b0;
				end else begin
					play_phase = play_phase + 1'b1;
					load_phase();
				end
			end
		end else if (en_q && item.pattern != PAT_NONE) begin
			if (pat_waiting.size() >= FIFO_DEPTH_DEF)
				drop = 1'b1;
			else
				pat_waiting.push_back(item.pattern);
		end
		r.led_level  = led_q;
		r.queue_fill = FILL_OUT_W'(pat_waiting.size());
		r.dropped    = drop;
		r.busy_res   = (play_pat != PAT_NONE);
		return r;
	endfunction

	// Request driver: a new request goes out only once the current one is taken.
	always @(negedge clk) begin : req_drive
		logic nxt_valid;
		req_t nxt_data;
		nxt_valid = req_if.valid;
		nxt_data = req_if.data;
		if (!arst_n) begin
			nxt_valid = 1'b0;
		end else if (!req_if.valid || req_fire) begin
			nxt_valid = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
			end else if (req_backlog.size() > 0) begin
				nxt_valid = 1'b1;
				nxt_data = req_backlog.pop_front();
				if (!calm && $urandom_range(0, 9) == 0)
					send_gap = $urandom_range(1, 19);
			end
		end
		req_if.valid <= nxt_valid;
		req_if.data <= nxt_data;
	end

	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt--;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= 1'b1;
			if (!calm && $urandom_range(0, 11) == 0)
				hold_cnt = $urandom_range(1, 19);
		end
	end

	always @(posedge clk) begin : track
		res_t want;
		res_t got;
		req_fire <= arst_n && req_if.valid && req_if.ready;
		if (arst_n && req_if.valid && req_if.ready) begin
			expected_status.push_back(step_player(req_if.data));
			accepted_cnt++;
		end
		if (arst_n && res_if.valid && res_if.ready) begin
			got = res_if.data;
			if (expected_status.size() == 0) begin
				$error("result with no request outstanding: %p", got);
				errors++;
			end else begin
				want = expected_status.pop_front();
				if (got.led_level !== want.led_level) begin
					$error("led_level expected %0d actual %0d", want.led_level, got.led_level);
					errors++;
				end
				if (got.queue_fill !== want.queue_fill) begin
					$error("queue_fill expected %0d actual %0d",
						want.queue_fill, got.queue_fill);
					errors++;
				end
				if (got.dropped !== want.dropped) begin
					$error("dropped expected %0d actual %0d", want.dropped, got.dropped);
					errors++;
				end
				if (got.busy_res !== want.busy_res) begin
					$error("busy_res expected %0d actual %0d", want.busy_res, got.busy_res);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic add_req(act_t a, pat_t p);
		req_t item;
		item.action = a;
		item.pattern = p;
		req_backlog.push_back(item);
		submitted_cnt++;
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [TICK_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			CFG_LED_ENABLE:  en_q = val[0];
			CFG_SHORT_TICKS: short_q = val;
			CFG_LONG_TICKS:  long_q = val;
			CFG_GAP_TICKS:   gap_q = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Holds off until every request is taken and every result is back.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (accepted_cnt != submitted_cnt || expected_status.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	function automatic pat_t pick_pattern();
		if ($urandom_range(0, 7) == 0)
			return PAT_NONE;
		return pat_t'($urandom_range(1, 3));
	endfunction

	function automatic logic [TICK_W-1:0] pick_ticks();
		if ($urandom_range(0, 5) == 0)
			return TICK_W'($urandom_range(7, 40));
		return TICK_W'($urandom_range(0, 6));
	endfunction

	// Mostly bursts of pattern requests and runs of ticks, with some noise.
	task automatic queue_traffic(int unsigned n);
		int unsigned added;
		int unsigned len;
		int unsigned kind;
		added = 0;
		while (added < n) begin
			kind = $urandom_range(0, 9);
			if (kind < 3) begin
				len = ($urandom_range(0, 12) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 5);
				repeat (len) add_req(ACT_ENQUEUE, pick_pattern());
			end else if (kind < 9) begin
				len = $urandom_range(1, 25);
				repeat (len) add_req(ACT_TICK, pat_t'($urandom_range(0, 3)));
			end else begin
				len = $urandom_range(1, 4);
				repeat (len) add_req(act_t'($urandom_range(0, 1)), pat_t'($urandom_range(0, 3)));
			end
			added += len;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		en_q = LED_ENABLE_RST;
		short_q = SHORT_TICKS_RST;
		long_q = LONG_TICKS_RST;
		gap_q = GAP_TICKS_RST;
		play_pat = PAT_NONE;
		play_phase = '0;
		play_timer = '0;
		led_q = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset defaults: idle tick on an empty queue, the none request,
		// each pattern, and requests that arrive while a pattern plays.
		add_req(ACT_TICK, PAT_RAPID);
		add_req(ACT_ENQUEUE, PAT_NONE);
		add_req(ACT_ENQUEUE, PAT_SHORT);
		add_req(ACT_ENQUEUE, PAT_LONG);
		add_req(ACT_ENQUEUE, PAT_RAPID);
		add_req(ACT_TICK, PAT_NONE);
		add_req(ACT_TICK, PAT_SHORT);
		add_req(ACT_ENQUEUE, PAT_RAPID);
		add_req(ACT_TICK, PAT_LONG);
		add_req(ACT_ENQUEUE, PAT_SHORT);
		wait_drained();

		for (int p = 0; p < 10; p++) begin
			calm = (p == 9) || ($urandom_range(0, 4) == 0);
			case (p)
				0: begin
					write_reg(CFG_LED_ENABLE, 20'd1);
					write_reg(CFG_SHORT_TICKS, 20'd0);
					write_reg(CFG_LONG_TICKS, 20'd0);
					write_reg(CFG_GAP_TICKS, 20'd0);
				end
				1: begin
					write_reg(CFG_SHORT_TICKS, 20'd1);
					write_reg(CFG_LONG_TICKS, 20'd1);
					write_reg(CFG_GAP_TICKS, 20'd1);
				end
				2: begin
					write_reg(CFG_LED_ENABLE, 20'd0);
					write_reg(CFG_SHORT_TICKS, pick_ticks());
				end
				default: begin
					write_reg(CFG_LED_ENABLE, TICK_W'($urandom_range(0, 5) != 0));
					write_reg(CFG_SHORT_TICKS, pick_ticks());
					write_reg(CFG_LONG_TICKS, pick_ticks());
					write_reg(CFG_GAP_TICKS, pick_ticks());
				end
			endcase
			queue_traffic(55);
			wait_drained();
		end

		// Longest durations: only the start of a pulse is within reach.
		calm = 1'b1;
		write_reg(CFG_LED_ENABLE, 20'd1);
		write_reg(CFG_SHORT_TICKS, TICKS_MAX);
		write_reg(CFG_LONG_TICKS, TICKS_MAX);
		write_reg(CFG_GAP_TICKS, TICKS_MAX);
		repeat (200) add_req(ACT_TICK, PAT_NONE);
		add_req(ACT_ENQUEUE, PAT_RAPID);
		add_req(ACT_ENQUEUE, PAT_LONG);
		repeat (40) add_req(ACT_TICK, PAT_NONE);

		do
			@(negedge clk);
		while (accepted_cnt != submitted_cnt || expected_status.size() != 0);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/lbpq_pkg.sv
rtl/core/lbpq_stream_if.sv
rtl/core/lbpq_fifo.sv
rtl/core/led_blink_pattern_queue.sv
dv/led_blink_pattern_queue_tb.sv
